// ===== rtl/core/swb_pkg.sv =====
// ----------------------------------------------------------------------------
// swb_pkg: shared types and constants of the single-wire bus master
// Holds the command codes, the phase encoding, the slot timing constants in
// microsecond ticks, and the structs passed between the step logic and the top.
// ----------------------------------------------------------------------------
package swb_pkg;

	// Command codes carried in the cmd field.
	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_DISC  = 3'd1,
		CMD_SS    = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	// Bus operation phases.
	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_DISC = 4'd1,
		PH_SS   = 4'd2,
		PH_WBIT = 4'd3,
		PH_WACK = 4'd4,
		PH_RBIT = 4'd5,
		PH_RACK = 4'd6
	} phase_t;

	typedef logic [9:0] tick_t;

	// Discovery reset timing.
	localparam tick_t DISC_TOTAL     = 10'd744;
	localparam tick_t DISC_SAMPLE    = 10'd723;
	localparam tick_t DISC_LOW_BEGIN = 10'd200;
	localparam tick_t DISC_LOW_END   = 10'd700;
	localparam tick_t DISC_PULSE     = 10'd720;

	// Start/stop release time, high-speed and standard.
	localparam tick_t SS_TOTAL_HS  = 10'd200;
	localparam tick_t SS_TOTAL_STD = 10'd650;

	// Bit slot timing, high-speed and standard.
	localparam tick_t ONE_LOW_HS   = 10'd1;
	localparam tick_t ONE_LOW_STD  = 10'd4;
	localparam tick_t ZERO_LOW_HS  = 10'd10;
	localparam tick_t ZERO_LOW_STD = 10'd24;
	localparam tick_t BIT_TOTAL_HS  = 10'd15;
	localparam tick_t BIT_TOTAL_STD = 10'd45;
	localparam tick_t RD_SAMPLE_HS  = 10'd2;
	localparam tick_t RD_SAMPLE_STD = 10'd6;
	localparam tick_t RD_TOTAL_HS   = 10'd11;
	localparam tick_t RD_TOTAL_STD  = 10'd40;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// Bus master state carried from item to item.
	typedef struct packed {
		phase_t     phase;
		tick_t      tick_count;
		logic [3:0] bit_index;
		logic [7:0] shift_reg;
		logic       nack_flag;
		logic       sampled_ack;
		logic       speed_mode;
		logic [7:0] last_read;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:       PH_IDLE,
		tick_count:  '0,
		bit_index:   '0,
		shift_reg:   '0,
		nack_flag:   1'b0,
		sampled_ack: 1'b0,
		speed_mode:  1'b0,
		last_read:   '0
	};

	// One input word, unpacked.
	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] data_byte;
		logic       end_read;
		logic       line_level;
	} item_t;

	// One result word, unpacked.
	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       ack_seen;
		logic [7:0] read_data;
		logic       rejected;
	} result_t;

endpackage

// ===== rtl/core/single_wire_bus_master.sv =====
// ----------------------------------------------------------------------------
// single_wire_bus_master: master for a single-wire open-drain EEPROM bus
// Each input word is one microsecond of bus time, either a tick or a command.
// The block returns one result word per input word with the line drive and
// operation status.
// ----------------------------------------------------------------------------
//  channel   | direction | tdata fields (low bit first)
//  s_axis    | in        | cmd[2:0] data_byte[10:3] end_read[11] line_level[12]
//  m_axis    | out       | drive_low[0] busy_res[1] done_res[2] ack_seen[3]
//            |           | read_data[11:4] rejected[12]
//  cfg       | in        | speed_mode, written when cfg_wen is high
//
// One word is accepted per clock while s_axis_tready is high; it is held in
// the input register, and its result is loaded into the output register, from which it is taken on m_axis.
// The bus state is updated by the combinational step logic, so the input
// register and the result register are the only registers on the path.
// A stall on m_axis holds the result register; once the input register also
// holds a word, that word is held and s_axis_tready is deasserted.
// Reset clears the bus state to idle and selects high-speed.
// ----------------------------------------------------------------------------
module single_wire_bus_master (
	input  logic        clk,
	input  logic        arst_n,
	// cmd[2:0], data_byte[10:3], end_read[11], line_level[12], zero pad
	input  logic [15:0] s_axis_tdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// drive_low[0], busy_res[1], done_res[2], ack_seen[3], read_data[11:4],
	// rejected[12], zero pad
	output logic [15:0] m_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic        cfg_wen,
	input  logic        cfg_wdata
);

	logic              valid_s1;
	swb_pkg::item_t    item_s1;
	logic              out_valid_q;
	swb_pkg::result_t  res_q;
	swb_pkg::state_t   st_q;
	swb_pkg::state_t   st_next;
	swb_pkg::result_t  res_next;
	logic              advance;

	// The pipeline moves when the output register is free or being taken.
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.cmd        <= s_axis_tdata[2:0];
			item_s1.data_byte  <= s_axis_tdata[10:3];
			item_s1.end_read   <= s_axis_tdata[11];
			item_s1.line_level <= s_axis_tdata[12];
		end
	end

	swb_step u_step (
		.st   (st_q),
		.item (item_s1),
		.nxt  (st_next),
		.res  (res_next)
	);

	// Bus state and speed register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= swb_pkg::STATE_RESET;
		end else if (cfg_wen) begin
			st_q.speed_mode <= cfg_wdata;
		end else if (advance && valid_s1) begin
			st_q <= st_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, res_q.rejected, res_q.read_data, res_q.ack_seen,
	                        res_q.done_res, res_q.busy_res, res_q.drive_low};

	// A finished operation never reports itself still busy.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.done_res && res_q.busy_res))
		else $error("done and busy in the same result");

	// A rejected command arrives only while an operation runs.
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.rejected) |-> (res_q.busy_res || res_q.done_res))
		else $error("command rejected while idle");

	// Idle state leaves the slot counters cleared.
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == swb_pkg::PH_IDLE) |-> (st_q.tick_count == '0 && st_q.bit_index == '0))
		else $error("counters not cleared in idle");

	// The bit counter never passes one byte.
	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.bit_index <= swb_pkg::BITS_PER_BYTE)
		else $error("bit index out of range");

endmodule

// ===== rtl/core/swb_step.sv =====
// ----------------------------------------------------------------------------
// swb_step: one-microsecond step of the bus master
// Combinational next-state and result logic for one input word: command
// start or rejection, slot timing, line drive, sampling and phase advance.
// ----------------------------------------------------------------------------
module swb_step (
	input  swb_pkg::state_t  st,
	input  swb_pkg::item_t   item,
	output swb_pkg::state_t  nxt,
	output swb_pkg::result_t res
);

	always_comb begin
		swb_pkg::state_t s;
		logic            is_cmd;
		logic            rej;
		logic            done;
		logic            drv;
		logic            has_samp;
		logic            bit_one;
		swb_pkg::tick_t  t;
		swb_pkg::tick_t  low;
		swb_pkg::tick_t  total;
		swb_pkg::tick_t  samp;
		logic [10:0]     t_inc;

		s        = st;
		rej      = 1'b0;
		done     = 1'b0;
		drv      = 1'b0;
		has_samp = 1'b0;
		bit_one  = 1'b0;
		low      = '0;
		total    = 10'd1;
		samp     = '0;

		// Start a command when idle, reject it otherwise.
		is_cmd = item.cmd inside {[swb_pkg::CMD_DISC : swb_pkg::CMD_READ]};
		if (is_cmd) begin
			if (s.phase != swb_pkg::PH_IDLE) begin
				rej = 1'b1;
			end else begin
				s.tick_count = '0;
				s.bit_index  = '0;
				case (swb_pkg::cmd_t'(item.cmd))
					swb_pkg::CMD_DISC: begin
						s.phase = swb_pkg::PH_DISC;
					end
					swb_pkg::CMD_SS: begin
						s.phase = swb_pkg::PH_SS;
					end
					swb_pkg::CMD_WRITE: begin
						s.shift_reg = item.data_byte;
						s.phase     = swb_pkg::PH_WBIT;
					end
					default: begin
						s.shift_reg = '0;
						s.nack_flag = item.end_read;
						s.phase     = swb_pkg::PH_RBIT;
					end
				endcase
			end
		end

		t     = s.tick_count;
		t_inc = {1'b0, t} + 11'd1;

		// Slot shape for the current phase and speed.
		case (s.phase)
			swb_pkg::PH_DISC: begin
				total    = swb_pkg::DISC_TOTAL;
				samp     = swb_pkg::DISC_SAMPLE;
				has_samp = 1'b1;
			end
			swb_pkg::PH_SS: begin
				total = s.speed_mode ? swb_pkg::SS_TOTAL_STD : swb_pkg::SS_TOTAL_HS;
			end
			swb_pkg::PH_WBIT, swb_pkg::PH_RACK: begin
				bit_one = (s.phase == swb_pkg::PH_WBIT) ? s.shift_reg[7] : s.nack_flag;
				if (bit_one) begin
					low = s.speed_mode ? swb_pkg::ONE_LOW_STD : swb_pkg::ONE_LOW_HS;
				end else begin
					low = s.speed_mode ? swb_pkg::ZERO_LOW_STD : swb_pkg::ZERO_LOW_HS;
				end
				total = s.speed_mode ? swb_pkg::BIT_TOTAL_STD : swb_pkg::BIT_TOTAL_HS;
			end
			swb_pkg::PH_WACK, swb_pkg::PH_RBIT: begin
				low      = s.speed_mode ? swb_pkg::ONE_LOW_STD : swb_pkg::ONE_LOW_HS;
				samp     = s.speed_mode ? swb_pkg::RD_SAMPLE_STD : swb_pkg::RD_SAMPLE_HS;
				total    = s.speed_mode ? swb_pkg::RD_TOTAL_STD : swb_pkg::RD_TOTAL_HS;
				has_samp = 1'b1;
			end
			default: begin
				total = 10'd1;
			end
		endcase

		if (s.phase != swb_pkg::PH_IDLE) begin
			// Line drive for this microsecond.
			if (s.phase == swb_pkg::PH_DISC) begin
				drv = (t >= swb_pkg::DISC_LOW_BEGIN && t < swb_pkg::DISC_LOW_END) ||
				      (t == swb_pkg::DISC_PULSE);
			end else begin
				drv = (t < low);
			end

			// Sample the line: data bits shift in, others record an acknowledge.
			if (has_samp && t == samp) begin
				if (s.phase == swb_pkg::PH_RBIT) begin
					s.shift_reg = {s.shift_reg[6:0], item.line_level};
				end else begin
					s.sampled_ack = ~item.line_level;
				end
			end

			// End of slot: advance bit, phase, or finish the operation.
			t = t_inc[9:0];
			if (t >= total) begin
				t = '0;
				case (s.phase)
					swb_pkg::PH_DISC: begin
						s.speed_mode = 1'b0;
						done         = 1'b1;
					end
					swb_pkg::PH_SS, swb_pkg::PH_WACK: begin
						done = 1'b1;
					end
					swb_pkg::PH_WBIT: begin
						s.shift_reg = {s.shift_reg[6:0], 1'b0};
						s.bit_index = s.bit_index + 4'd1;
						if (s.bit_index >= swb_pkg::BITS_PER_BYTE) begin
							s.phase = swb_pkg::PH_WACK;
						end
					end
					swb_pkg::PH_RBIT: begin
						s.bit_index = s.bit_index + 4'd1;
						if (s.bit_index >= swb_pkg::BITS_PER_BYTE) begin
							s.phase = swb_pkg::PH_RACK;
						end
					end
					default: begin
						s.last_read = s.shift_reg;
						done        = 1'b1;
					end
				endcase
				if (done) begin
					s.phase     = swb_pkg::PH_IDLE;
					s.bit_index = '0;
				end
			end
			s.tick_count = t;
		end

		nxt           = s;
		res.drive_low = drv;
		res.busy_res  = (s.phase != swb_pkg::PH_IDLE);
		res.done_res  = done;
		res.ack_seen  = s.sampled_ack;
		res.read_data = s.last_read;
		res.rejected  = rej;
	end

endmodule
